>>> hdl/band_limited_wavetable_oscillator_assert.svh
// Assertion macros for the wavetable oscillator.
// Used by modules that check their own sequencing; no other dependencies.
`ifndef BAND_LIMITED_WAVETABLE_OSCILLATOR_ASSERT_SVH
`define BAND_LIMITED_WAVETABLE_OSCILLATOR_ASSERT_SVH

// same-cycle implication
`define BLWO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BLWO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/blwo_pkg.sv
// Shared types and constants for the wavetable oscillator.
// No dependencies; imported by the phase, interpolator and top modules.
package blwo_pkg;

   localparam logic [1:0] MODE_LOAD_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_LOAD_LIMIT  = 2'd1;
   localparam logic [1:0] MODE_GENERATE    = 2'd2;

   localparam int FRAC_BITS = 20;
   localparam int USED_W    = 7;   // holds a band count up to 64

   typedef struct packed {
      logic        [1:0]  mode;
      logic        [4:0]  band;
      logic        [11:0] sample_address;
      logic signed [15:0] sample_value;
      logic        [31:0] band_limit;
      logic        [2:0]  voice;
      logic        [31:0] voice_increment;
      logic        [31:0] base_increment;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic        [2:0]  voice_out;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [15:0] s0;
      logic signed [15:0] s1;
      logic        [15:0] frac;
   } interp_in_type;

   typedef struct packed {
      logic               valid;
      logic signed [15:0] sample;
   } interp_res_type;

endpackage

>>> hdl/blwo_store.sv
// Wave table store and band limit store, synchronous RAMs with registered reads.
// Depends on nothing but its parameters.
module blwo_store #(
   parameter int  NUM_BANDS  = 32,
   parameter int  TABLE_SIZE = 4096,
   localparam int BAND_AW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
   localparam int WAVE_AW    = $clog2(NUM_BANDS * TABLE_SIZE)
) (
   input  logic                      clock,
   input  logic                      wave_we,
   input  logic        [WAVE_AW-1:0] wave_wr_addr,
   input  logic signed [15:0]        wave_wr_data,
   input  logic                      wave_rd_en,
   input  logic        [WAVE_AW-1:0] wave_rd_addr,
   output logic signed [15:0]        wave_rd_data,
   input  logic                      lim_we,
   input  logic        [BAND_AW-1:0] lim_wr_addr,
   input  logic        [31:0]        lim_wr_data,
   input  logic                      lim_rd_en,
   input  logic        [BAND_AW-1:0] lim_rd_addr,
   output logic        [31:0]        lim_rd_data
);

   logic signed [15:0] wave_mem [NUM_BANDS * TABLE_SIZE];
   logic        [31:0] lim_mem  [NUM_BANDS];
   logic signed [15:0] wave_rd_ff;
   logic        [31:0] lim_rd_ff;

   always_ff @(posedge clock) begin
      if (wave_we) begin
         wave_mem[wave_wr_addr] <= wave_wr_data;
      end
      if (wave_rd_en) begin
         wave_rd_ff <= wave_mem[wave_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (lim_we) begin
         lim_mem[lim_wr_addr] <= lim_wr_data;
      end
      if (lim_rd_en) begin
         lim_rd_ff <= lim_mem[lim_rd_addr];
      end
   end

   assign wave_rd_data = wave_rd_ff;
   assign lim_rd_data  = lim_rd_ff;

endmodule

>>> hdl/blwo_phase.sv
// Per-voice phase RAM with read-modify-write advance modulo the table length.
// Uses blwo_pkg for the fraction width.
module blwo_phase #(
   parameter int  NUM_VOICES = 8,
   parameter int  TABLE_SIZE = 4096,
   localparam int VOICE_AW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
   localparam int PHASE_W    = ($clog2(TABLE_SIZE) + blwo_pkg::FRAC_BITS < 32)
                               ? $clog2(TABLE_SIZE) + blwo_pkg::FRAC_BITS : 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [VOICE_AW-1:0] rd_voice,
   input  logic                advance_en,
   input  logic [31:0]         increment,
   output logic [31:0]         phase_q
);
   import blwo_pkg::*;

   logic [PHASE_W-1:0]  phase_mem [NUM_VOICES];
   logic [NUM_VOICES-1:0] written_ff, written_in;
   logic [PHASE_W-1:0]  rd_data_ff;
   logic                rd_written_ff;
   logic [VOICE_AW-1:0] voice_ff;
   logic [32:0]         sum;
   logic [PHASE_W-1:0]  phase_new;

   // an entry never written reads as zero phase
   assign phase_q   = rd_written_ff ? 32'(rd_data_ff) : 32'd0;
   assign sum       = {1'b0, phase_q} + {1'b0, increment};
   assign phase_new = sum[PHASE_W-1:0];

   always_comb begin
      written_in = written_ff;
      if (advance_en) begin
         written_in[voice_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff    <= phase_mem[rd_voice];
         rd_written_ff <= written_ff[rd_voice];
         voice_ff      <= rd_voice;
      end
      if (advance_en) begin
         phase_mem[voice_ff] <= phase_new;
      end
   end

endmodule

>>> hdl/blwo_interp.sv
// Three-stage linear interpolator: difference, multiply, floor shift and add.
// Uses blwo_pkg for its request and result structs.
module blwo_interp (
   input  logic                     clock,
   input  logic                     reset,
   input  blwo_pkg::interp_in_type  interp_in,
   input  logic                     take,
   output blwo_pkg::interp_res_type interp_res
);
   import blwo_pkg::*;

   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [16:0] diff_ff;
   logic        [15:0] frac_ff;
   logic signed [15:0] s0_1_ff, s0_2_ff, sample_ff;
   logic signed [33:0] prod_ff;

   assign v1_in = interp_in.start;
   assign v2_in = v1_ff;
   // result holds until the control takes it
   assign v3_in = v2_ff | (v3_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (interp_in.start) begin
         diff_ff <= $signed({interp_in.s1[15], interp_in.s1})
                  - $signed({interp_in.s0[15], interp_in.s0});
         frac_ff <= interp_in.frac;
         s0_1_ff <= interp_in.s0;
      end
      if (v1_ff) begin
         prod_ff <= 34'($signed({1'b0, frac_ff})) * 34'(diff_ff);
         s0_2_ff <= s0_1_ff;
      end
      if (v2_ff) begin
         // prod >>> 16 floors; the sum always fits in 16 bits
         sample_ff <= s0_2_ff + $signed(prod_ff[31:16]);
      end
   end

   assign interp_res.valid  = v3_ff;
   assign interp_res.sample = sample_ff;

endmodule

>>> hdl/band_limited_wavetable_oscillator.sv
// Wavetable oscillator top: request decode, serial band search, phase and table sequencing.
// Generate request: band search, phase advance and two table reads, then the interpolator; the
// result is later while the previous result is still held. Requests are taken again in the same
// cycle as the result goes valid. The band search reads one limit a cycle from its RAM.
// Load requests and ignored requests complete on acceptance. Synchronous active-high reset
// clears voice phases to zero and bands in use to one; table contents stay undefined.
`include "band_limited_wavetable_oscillator_assert.svh"
module band_limited_wavetable_oscillator #(
   parameter int TABLE_SIZE = 4096,
   parameter int NUM_BANDS  = 32,
   parameter int NUM_VOICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  blwo_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output blwo_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [5:0]        csr_wdata
);
   import blwo_pkg::*;

   localparam int TABLE_LOG2 = $clog2(TABLE_SIZE);
   localparam int BAND_AW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int WAVE_AW    = $clog2(NUM_BANDS * TABLE_SIZE);
   localparam int VOICE_AW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_RD0, S_RD1, S_INTERP, S_WAIT
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [BAND_AW-1:0] band_ff, band_in;
   logic signed [15:0] s0_ff, s0_in;
   logic [5:0]         bands_in_use_ff, bands_in_use_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [USED_W-1:0]     used_eff;
   logic                  req_accept, gen_accept, scan_more, slot_free;
   logic [BAND_AW-1:0]    band_next;
   logic [31:0]           phase_q;
   logic [TABLE_LOG2-1:0] idx0, idx1;
   logic [15:0]           frac;

   logic                      wave_we, wave_rd_en, lim_we, lim_rd_en;
   logic        [WAVE_AW-1:0] wave_wr_addr, wave_rd_addr;
   logic signed [15:0]        wave_rd_data;
   logic        [BAND_AW-1:0] lim_rd_addr;
   logic        [31:0]        lim_rd_data;
   interp_in_type             interp_in;
   interp_res_type            interp_res;
   logic                      interp_take;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid & req_ready;
   assign gen_accept = req_accept && (req_payload.mode == MODE_GENERATE)
                       && (32'(req_payload.voice) < 32'(NUM_VOICES));
   assign slot_free  = ~rsp_valid_ff | rsp_ready;

   // zero counts as one, anything beyond the built bands saturates
   always_comb begin
      if (bands_in_use_ff == 6'd0) begin
         used_eff = USED_W'(1);
      end else if (USED_W'(bands_in_use_ff) > USED_W'(NUM_BANDS)) begin
         used_eff = USED_W'(NUM_BANDS);
      end else begin
         used_eff = USED_W'(bands_in_use_ff);
      end
   end

   assign band_next = band_ff + BAND_AW'(1);
   assign scan_more = (USED_W'(band_ff) + USED_W'(1) < used_eff)
                      && (req_ff.base_increment >= lim_rd_data);

   assign idx0 = TABLE_LOG2'(phase_q[31:FRAC_BITS]);
   assign idx1 = idx0 + TABLE_LOG2'(1);
   assign frac = phase_q[FRAC_BITS-1 -: 16];

   // loads go straight to the stores on acceptance
   assign wave_we = req_accept && (req_payload.mode == MODE_LOAD_SAMPLE)
                    && (32'(req_payload.band) < 32'(NUM_BANDS))
                    && (32'(req_payload.sample_address) < 32'(TABLE_SIZE));
   assign wave_wr_addr = WAVE_AW'({BAND_AW'(req_payload.band),
                                   TABLE_LOG2'(req_payload.sample_address)});
   assign lim_we = req_accept && (req_payload.mode == MODE_LOAD_LIMIT)
                   && (32'(req_payload.band) < 32'(NUM_BANDS));

   // limit of band 0 is fetched while idle; the scan prefetches the next band
   assign lim_rd_en   = (state_ff == S_IDLE) || ((state_ff == S_SCAN) && scan_more);
   assign lim_rd_addr = (state_ff == S_SCAN) ? band_next : '0;

   assign wave_rd_en   = (state_ff == S_RD0) || (state_ff == S_RD1);
   assign wave_rd_addr = (state_ff == S_RD0) ? WAVE_AW'({band_ff, idx0})
                                             : WAVE_AW'({band_ff, idx1});

   assign interp_in.start = (state_ff == S_INTERP);
   assign interp_in.s0    = s0_ff;
   assign interp_in.s1    = wave_rd_data;
   assign interp_in.frac  = frac;
   assign interp_take     = (state_ff == S_WAIT) && interp_res.valid && slot_free;

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      band_in         = band_ff;
      s0_in           = s0_ff;
      bands_in_use_in = csr_we ? csr_wdata : bands_in_use_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_in          = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in = req_payload;
            end
            if (gen_accept) begin
               band_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_more) begin
               band_in = band_next;
            end else begin
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            state_in = S_RD1;
         end
         S_RD1: begin
            s0_in    = wave_rd_data;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (interp_take) begin
               rsp_valid_in      = 1'b1;
               rsp_in.sample_out = interp_res.sample;
               rsp_in.voice_out  = req_ff.voice;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         bands_in_use_ff <= 6'd1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bands_in_use_ff <= bands_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      req_ff  <= req_in;
      band_ff <= band_in;
      s0_ff   <= s0_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   blwo_store #(
      .NUM_BANDS  (NUM_BANDS),
      .TABLE_SIZE (TABLE_SIZE)
   ) u_store (
      .clock        (clock),
      .wave_we      (wave_we),
      .wave_wr_addr (wave_wr_addr),
      .wave_wr_data (req_payload.sample_value),
      .wave_rd_en   (wave_rd_en),
      .wave_rd_addr (wave_rd_addr),
      .wave_rd_data (wave_rd_data),
      .lim_we       (lim_we),
      .lim_wr_addr  (BAND_AW'(req_payload.band)),
      .lim_wr_data  (req_payload.band_limit),
      .lim_rd_en    (lim_rd_en),
      .lim_rd_addr  (lim_rd_addr),
      .lim_rd_data  (lim_rd_data)
   );

   blwo_phase #(
      .NUM_VOICES (NUM_VOICES),
      .TABLE_SIZE (TABLE_SIZE)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (gen_accept),
      .rd_voice   (VOICE_AW'(req_payload.voice)),
      .advance_en (state_ff == S_RD0),
      .increment  (req_ff.voice_increment),
      .phase_q    (phase_q)
   );

   blwo_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .interp_in  (interp_in),
      .take       (interp_take),
      .interp_res (interp_res)
   );

   `BLWO_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == S_SCAN, USED_W'(band_ff) < used_eff, "band search past bands in use")
   `BLWO_ASSERT_IMP(a_result_in_wait, clock, reset, interp_res.valid, state_ff == S_WAIT, "interpolator result outside wait state")
   `BLWO_ASSERT_NEXT(a_gen_starts_scan, clock, reset, gen_accept, state_ff == S_SCAN, "generate request did not start band search")
   `BLWO_ASSERT_NEXT(a_load_stays_idle, clock, reset, req_accept && !gen_accept, state_ff == S_IDLE, "load request left idle")

endmodule

>>> tb/band_limited_wavetable_oscillator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for band_limited_wavetable_oscillator: table, limit and generate requests.
// Depends on blwo_pkg and the oscillator RTL; an internal model predicts every sample.
module band_limited_wavetable_oscillator_tb;
   import blwo_pkg::*;

   localparam int TBL_DEPTH     = 4096;
   localparam int BAND_COUNT    = 32;
   localparam int VOICE_COUNT   = 8;
   localparam int SETTLE_CYCLES = 50;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 80;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_we      = 1'b0;
   logic [5:0] csr_wdata   = '0;

   // model of the block, updated on accepted requests
   logic [15:0] model_wave  [BAND_COUNT*TBL_DEPTH];
   logic [31:0] model_limit [BAND_COUNT];
   logic [31:0] model_phase [VOICE_COUNT];
   logic [5:0]  model_bands;

   // planning shadow, updated as requests are queued, so no unwritten entry is read
   bit          plan_written [BAND_COUNT*TBL_DEPTH];
   logic [31:0] plan_limit   [BAND_COUNT];
   logic [31:0] plan_phase   [VOICE_COUNT];
   logic [5:0]  plan_bands;

   req_type       pending_requests [$];
   rsp_type       expected_samples [$];
   idle_mode_type idle_mode   = IDLE_NONE;
   int            fail_count  = 0;
   int            phase_items = 0;

   band_limited_wavetable_oscillator #(
      .TABLE_SIZE(TBL_DEPTH),
      .NUM_BANDS (BAND_COUNT),
      .NUM_VOICES(VOICE_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit stall_now(bit for_sender);
      int pct;
      case (idle_mode)
         IDLE_SENDER:   pct = for_sender ? 56 : 0;
         IDLE_RECEIVER: pct = for_sender ? 0 : 56;
         IDLE_BOTH:     pct = 32;
         default:       pct = 0;
      endcase
      return $urandom_range(99) < pct;
   endfunction

   // first band whose limit exceeds base, capped at the last band in use
   function automatic int unsigned select_band(bit from_plan, logic [5:0] count,
                                               logic [31:0] base);
      int unsigned used;
      int unsigned b;
      bit          found;
      logic [31:0] lim;
      used  = (count == 0) ? 1 : count;
      if (used > BAND_COUNT) used = BAND_COUNT;
      b     = 0;
      found = 1'b0;
      while (!found && b + 1 < used) begin
         lim = from_plan ? plan_limit[b] : model_limit[b];
         if (base < lim) found = 1'b1;
         else b++;
      end
      return b;
   endfunction

   task automatic log_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic predict_request(req_type rq);
      int unsigned        sel;
      int unsigned        i0;
      int unsigned        i1;
      logic [15:0]        frac;
      logic signed [15:0] s0;
      logic signed [15:0] s1;
      longint             step;
      longint             sum;
      rsp_type            rs;
      case (rq.mode)
         MODE_LOAD_SAMPLE: begin
            if (rq.band < BAND_COUNT && rq.sample_address < TBL_DEPTH)
               model_wave[int'(rq.band)*TBL_DEPTH + int'(rq.sample_address)] = rq.sample_value;
         end
         MODE_LOAD_LIMIT: begin
            if (rq.band < BAND_COUNT) model_limit[rq.band] = rq.band_limit;
         end
         MODE_GENERATE: begin
            if (rq.voice < VOICE_COUNT) begin
               sel  = select_band(1'b0, model_bands, rq.base_increment);
               i0   = (model_phase[rq.voice] >> FRAC_BITS) % TBL_DEPTH;
               i1   = (i0 + 1) % TBL_DEPTH;
               frac = 16'(model_phase[rq.voice] >> (FRAC_BITS - 16));
               s0   = model_wave[sel*TBL_DEPTH + i0];
               s1   = model_wave[sel*TBL_DEPTH + i1];
               // arithmetic shift of a signed product floors
               step = (longint'(frac) * (longint'(s1) - longint'(s0))) >>> 16;
               sum  = longint'(s0) + step;
               rs.sample_out = 16'(sum);
               rs.voice_out  = rq.voice;
               expected_samples = {expected_samples, rs};
               model_phase[rq.voice] = 32'((longint'(model_phase[rq.voice]) +
                  longint'(rq.voice_increment)) % (longint'(TBL_DEPTH) << FRAC_BITS));
            end
         end
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() != 0 && !stall_now(1'b1)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && !stall_now(1'b0);
   end

   // monitor: predicts on accepted requests, checks accepted results
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         for (int v = 0; v < VOICE_COUNT; v++) model_phase[v] = '0;
         model_bands = 6'd1;
      end else begin
         if (csr_we) model_bands = csr_wdata;
         if (req_valid && req_ready) predict_request(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               log_failure($sformatf("unexpected sample %0d from voice %0d",
                                     rsp_payload.sample_out, rsp_payload.voice_out));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_payload.sample_out !== want.sample_out ||
                   rsp_payload.voice_out !== want.voice_out)
                  log_failure($sformatf("got voice %0d sample %0d, expected voice %0d sample %0d",
                                        rsp_payload.voice_out, rsp_payload.sample_out,
                                        want.voice_out, want.sample_out));
            end
         end
      end
   end

   function automatic req_type random_request(logic [1:0] mode);
      req_type rq;
      rq.mode            = mode;
      rq.band            = 5'($urandom);
      rq.sample_address  = 12'($urandom);
      if ($urandom_range(4) == 0) rq.sample_value = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
      else rq.sample_value = 16'($urandom);
      rq.band_limit      = $urandom;
      rq.voice           = 3'($urandom);
      rq.voice_increment = $urandom;
      rq.base_increment  = $urandom;
      return rq;
   endfunction

   task automatic push_request(req_type rq);
      case (rq.mode)
         MODE_LOAD_SAMPLE: plan_written[int'(rq.band)*TBL_DEPTH + int'(rq.sample_address)] = 1'b1;
         MODE_LOAD_LIMIT:  plan_limit[rq.band] = rq.band_limit;
         // the table spans the full 32-bit phase, so plain wrap-around is the modulus
         MODE_GENERATE:    plan_phase[rq.voice] = plan_phase[rq.voice] + rq.voice_increment;
         default: ;
      endcase
      pending_requests = {pending_requests, rq};
      if (rq.mode != MODE_UNUSED) phase_items++;
   endtask

   task automatic push_load(logic [4:0] band, logic [11:0] addr, logic [15:0] value);
      req_type rq;
      rq                = random_request(MODE_LOAD_SAMPLE);
      rq.band           = band;
      rq.sample_address = addr;
      rq.sample_value   = value;
      push_request(rq);
   endtask

   task automatic push_limit(logic [4:0] band, logic [31:0] value);
      req_type rq;
      rq            = random_request(MODE_LOAD_LIMIT);
      rq.band       = band;
      rq.band_limit = value;
      push_request(rq);
   endtask

   // fills in any table entry the generate request would read, then queues it
   task automatic push_generate(logic [2:0] voice, logic [31:0] vinc, logic [31:0] base);
      req_type     rq;
      int unsigned sel;
      int unsigned idx;
      sel = select_band(1'b1, plan_bands, base);
      for (int k = 0; k < 2; k++) begin
         idx = ((plan_phase[voice] >> FRAC_BITS) + k) % TBL_DEPTH;
         if (!plan_written[sel*TBL_DEPTH + idx]) begin
            rq                = random_request(MODE_LOAD_SAMPLE);
            rq.band           = 5'(sel);
            rq.sample_address = 12'(idx);
            push_request(rq);
         end
      end
      rq                 = random_request(MODE_GENERATE);
      rq.voice           = voice;
      rq.voice_increment = vinc;
      rq.base_increment  = base;
      push_request(rq);
   endtask

   function automatic logic [31:0] random_increment();
      case ($urandom_range(4))
         0:       return 32'($urandom_range(32'h003F_FFFF));   // stays near written entries
         1:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         2:       return {12'($urandom), 20'd0};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_base();
      logic [31:0] lim;
      case ($urandom_range(5))
         0: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         1: begin
            // right at a band edge
            lim = plan_limit[$urandom_range(BAND_COUNT - 1)];
            return lim + 32'($urandom_range(2)) - 32'd1;
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic random_step();
      logic [2:0]  voice;
      logic [31:0] vinc;
      int unsigned pick;
      int unsigned b;
      pick = $urandom_range(99);
      if (pick < 55) begin
         push_generate(3'($urandom), random_increment(), random_base());
      end else if (pick < 70) begin
         push_request(random_request(MODE_LOAD_SAMPLE));
      end else if (pick < 83) begin
         b = $urandom_range(BAND_COUNT - 1);
         if ($urandom_range(3) != 0) push_limit(5'(b), {5'(b), 27'($urandom)});
         else push_limit(5'(b), $urandom);
      end else if (pick < 91) begin
         push_request(random_request(MODE_UNUSED));
      end else begin
         // run of samples on one voice
         voice = 3'($urandom);
         vinc  = 32'($urandom_range(32'h0030_0000));
         repeat ($urandom_range(6, 2)) push_generate(voice, vinc, random_base());
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_bands(logic [5:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      plan_bands = value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [5:0] band_settings [8];
      band_settings = '{6'd2, 6'd32, 6'd0, 6'd17, 6'd63, 6'd1, 6'd33, 6'd9};
      for (int v = 0; v < VOICE_COUNT; v++) plan_phase[v] = '0;
      plan_bands = 6'd1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of value, address, band, fraction and wrap at the table end
      push_load(5'd0, 12'd0, 16'h7FFF);
      push_load(5'd0, 12'd1, 16'h8000);
      push_load(5'd0, 12'd4095, 16'h8000);
      push_load(5'd31, 12'd4095, 16'h7FFF);
      push_load(5'd0, 12'd2, 16'h0000);
      push_limit(5'd0, 32'h0);
      push_limit(5'd31, 32'hFFFF_FFFF);
      push_request(random_request(MODE_UNUSED));
      push_generate(3'd0, 32'h000F_FFF0, 32'h0);
      push_generate(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // full fraction, phase wraps
      push_generate(3'd0, 32'hFFF0_0000, 32'h0);
      push_generate(3'd0, 32'h0, 32'h0);                   // last sample and first
      push_generate(3'd7, 32'h0010_0000, 32'h0);
      push_generate(3'd7, 32'h0, 32'h0);
      // every limit written before more than one band is in use
      for (int b = 0; b < BAND_COUNT; b++) push_limit(5'(b), {5'(b), 27'($urandom)});

      foreach (band_settings[p]) begin
         wait_drained();
         write_bands(band_settings[p]);
         idle_mode   = idle_mode_type'(p % 4);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) random_step();
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("** band_limited_wavetable_oscillator: PASSED **");
      end else begin
         $display("** band_limited_wavetable_oscillator: FAILED **");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** band_limited_wavetable_oscillator: FAILED **");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/blwo_pkg.sv
hdl/blwo_store.sv
hdl/blwo_phase.sv
hdl/blwo_interp.sv
hdl/band_limited_wavetable_oscillator.sv
tb/band_limited_wavetable_oscillator_tb.sv
